// File: hdl/lbwtf_pkg.sv
// shared types, constants and helpers for the learned binary window table filter
package lbwtf_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned PatW  = 9;
  localparam int unsigned Depth = 1 << PatW;
  localparam int unsigned DistW = $clog2(PatW + 2);

  localparam logic [PixW-1:0]  UnseenVal = PixW'(128);
  localparam logic [DistW-1:0] BestInit  = DistW'(PatW + 1);

  localparam logic KindQuery = 1'b0;
  localparam logic KindFill  = 1'b1;

  typedef enum logic [1:0] {
    CmdTrain = 2'd0,
    CmdFill  = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDrain,
    StScan,
    StLast,
    StDone
  } state_e;

  typedef struct packed {
    logic            seen;
    logic [PixW-1:0] value;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  function automatic logic [DistW-1:0] popcount(logic [PatW-1:0] v);
    logic [DistW-1:0] n;
    n = '0;
    for (int k = 0; k < PatW; k++) begin
      n = n + DistW'(v[k]);
    end
    return n;
  endfunction

endpackage

// File: hdl/lbwtf_ram.sv
// generic single-write, single-read ram with registered read data
module lbwtf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/learned_binary_window_table_filter.sv
// top level: binary 3x3 window pattern table with train, fill and query commands
//
// Input channel: in_valid_i / in_stall_o with command and nine window pixels
// plus a target pixel. Each pixel counts as 1 when nonzero; the nine bits
// (top left first) address a 512-entry table. Output channel: out_valid_o /
// out_stall_i with result_kind_o and out_pixel_o.
// Train writes the target and gives no result. Query returns the entry via
// the read stage and the output register. A raster stream runs at one item
// per cycle while the output does not stall; the single table read port sets that.
// Fill walks every entry i and scans all 512 entries for the nearest seen one
// (lowest index wins ties), one table read per cycle, then gives one
// fill-finished result with pixel 0.
// Command 3 is dropped without a result.
// After reset the block writes every entry back to unseen (128) with stall
// high, then accepts items.
// A stalled receiver holds the output register; one more query may sit in
// the read stage, after which the input stalls too.
module learned_binary_window_table_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] pixel_top_left_i,
  input  logic [7:0] pixel_top_i,
  input  logic [7:0] pixel_top_right_i,
  input  logic [7:0] pixel_left_i,
  input  logic [7:0] pixel_center_i,
  input  logic [7:0] pixel_right_i,
  input  logic [7:0] pixel_bottom_left_i,
  input  logic [7:0] pixel_bottom_i,
  input  logic [7:0] pixel_bottom_right_i,
  input  logic [7:0] target_pixel_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       result_kind_o,
  output logic [7:0] out_pixel_o
);

  localparam int unsigned PatW  = lbwtf_pkg::PatW;
  localparam int unsigned DistW = lbwtf_pkg::DistW;
  localparam int unsigned PixW  = lbwtf_pkg::PixW;

  lbwtf_pkg::state_e state_q, state_d;
  logic [PatW-1:0]   i_q, i_d;
  logic [PatW-1:0]   j_q, j_d;
  logic [PatW-1:0]   rj_q, rj_d;
  logic              rv_q, rv_d;
  logic [DistW-1:0]  best_q, best_d, best_n;
  logic [PixW-1:0]   val_q, val_d, val_n;
  logic              self_q, self_d, self_n;

  logic              rd_valid_q, rd_valid_d;
  logic              rd_kind_q, rd_kind_d;
  logic              rd_push, rd_kind_in, rd_ready, out_ready;

  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic [PixW-1:0]   out_pixel_q, out_pixel_d;

  logic              ram_we, ram_re;
  logic [PatW-1:0]   ram_waddr, ram_raddr;
  lbwtf_pkg::entry_t ram_wdata, ram_ent;
  logic [lbwtf_pkg::EntryW-1:0] ram_rdata;

  logic [PatW-1:0]   pattern;
  logic [DistW-1:0]  ham_dist;
  logic              in_stall;

  assign pattern = {pixel_top_left_i != '0, pixel_top_i != '0, pixel_top_right_i != '0,
                    pixel_left_i != '0, pixel_center_i != '0, pixel_right_i != '0,
                    pixel_bottom_left_i != '0, pixel_bottom_i != '0,
                    pixel_bottom_right_i != '0};

  lbwtf_ram #(
    .Width (lbwtf_pkg::EntryW),
    .Depth (lbwtf_pkg::Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_ent  = lbwtf_pkg::entry_t'(ram_rdata);
  assign ham_dist = lbwtf_pkg::popcount(i_q ^ rj_q);

  // nearest-seen tracking over the data returned by the scan
  always_comb begin
    best_n = best_q;
    val_n  = val_q;
    self_n = self_q;
    if (rv_q) begin
      if (rj_q == i_q) begin
        self_n = ram_ent.seen;
      end
      if (ram_ent.seen && (ham_dist < best_q)) begin
        best_n = ham_dist;
        val_n  = ram_ent.value;
      end
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;
  assign rd_ready  = !rd_valid_q || out_ready;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    rj_d       = j_q;
    rv_d       = 1'b0;
    best_d     = best_q;
    val_d      = val_q;
    self_d     = self_q;
    ram_we     = 1'b0;
    ram_waddr  = i_q;
    ram_wdata  = '{seen: 1'b0, value: lbwtf_pkg::UnseenVal};
    ram_re     = 1'b0;
    ram_raddr  = pattern;
    rd_push    = 1'b0;
    rd_kind_in = lbwtf_pkg::KindQuery;
    in_stall   = 1'b1;
    case (state_q)
      lbwtf_pkg::StClear: begin
        ram_we = 1'b1;
        i_d    = i_q + 1'b1;
        if (&i_q) begin
          state_d = lbwtf_pkg::StIdle;
        end
      end
      lbwtf_pkg::StIdle: begin
        in_stall = !rd_ready;
        if (in_valid_i && rd_ready) begin
          case (command_i)
            lbwtf_pkg::CmdTrain: begin
              ram_we    = 1'b1;
              ram_waddr = pattern;
              ram_wdata = '{seen: 1'b1, value: target_pixel_i};
            end
            lbwtf_pkg::CmdFill: begin
              i_d     = '0;
              state_d = lbwtf_pkg::StDrain;
            end
            lbwtf_pkg::CmdQuery: begin
              ram_re  = 1'b1;
              rd_push = 1'b1;
            end
            default: ;
          endcase
        end
      end
      lbwtf_pkg::StDrain: begin
        // a held query answer lives in the ram read register
        if (!rd_valid_q) begin
          state_d = lbwtf_pkg::StScan;
          j_d     = '0;
          best_d  = lbwtf_pkg::BestInit;
          val_d   = '0;
          self_d  = 1'b0;
        end
      end
      lbwtf_pkg::StScan: begin
        ram_re    = 1'b1;
        ram_raddr = j_q;
        rv_d      = 1'b1;
        j_d       = j_q + 1'b1;
        best_d    = best_n;
        val_d     = val_n;
        self_d    = self_n;
        if (&j_q) begin
          state_d = lbwtf_pkg::StLast;
        end
      end
      lbwtf_pkg::StLast: begin
        ram_we    = !self_n;
        ram_waddr = i_q;
        ram_wdata = '{seen: 1'b1, value: val_n};
        if (&i_q) begin
          state_d = lbwtf_pkg::StDone;
        end else begin
          i_d     = i_q + 1'b1;
          j_d     = '0;
          best_d  = lbwtf_pkg::BestInit;
          val_d   = '0;
          self_d  = 1'b0;
          state_d = lbwtf_pkg::StScan;
        end
      end
      lbwtf_pkg::StDone: begin
        if (rd_ready) begin
          rd_push    = 1'b1;
          rd_kind_in = lbwtf_pkg::KindFill;
          state_d    = lbwtf_pkg::StIdle;
        end
      end
      default: begin
        state_d = lbwtf_pkg::StIdle;
      end
    endcase
  end

  // read stage and output register
  always_comb begin
    rd_valid_d  = rd_valid_q;
    rd_kind_d   = rd_kind_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_pixel_d = out_pixel_q;
    if (rd_ready) begin
      rd_valid_d = rd_push;
      rd_kind_d  = rd_kind_in;
    end
    if (out_ready) begin
      out_valid_d = rd_valid_q;
      out_kind_d  = rd_kind_q;
      out_pixel_d = (rd_kind_q == lbwtf_pkg::KindFill) ? '0 : ram_ent.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbwtf_pkg::StClear;
      i_q         <= '0;
      j_q         <= '0;
      rv_q        <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      rv_q        <= rv_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rj_q        <= rj_d;
    best_q      <= best_d;
    val_q       <= val_d;
    self_q      <= self_d;
    rd_kind_q   <= rd_kind_d;
    out_kind_q  <= out_kind_d;
    out_pixel_q <= out_pixel_d;
  end

  assign in_stall_o    = in_stall;
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign out_pixel_o   = out_pixel_q;

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lbwtf_pkg::StClear |-> in_stall_o)
    else $error("item taken during table clear");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_scan_rd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbwtf_pkg::StScan || state_q == lbwtf_pkg::StLast) |-> !rd_valid_q)
    else $error("fill scan overlaps a held query answer");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == lbwtf_pkg::KindFill |-> out_pixel_o == '0)
    else $error("fill finished result carries a nonzero pixel");

endmodule

// File: tb/testbench.sv
// self-checking bench for the learned binary window table filter: directed table, then random
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PatW       = lbwtf_pkg::PatW;
  localparam int unsigned PixW       = lbwtf_pkg::PixW;
  localparam int unsigned Depth      = lbwtf_pkg::Depth;
  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned DirN       = 25;
  localparam int unsigned RandN      = 880;
  localparam int unsigned RandFillAt = 440;
  localparam int unsigned CalmLo     = 560;
  localparam int unsigned CalmHi     = 720;
  localparam int unsigned IdlePct    = 14;
  // a fill walk makes no transfer; the limit leaves room for a whole walk
  localparam int unsigned QuietLimit = 800_000;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [PatW-1:0][PixW-1:0] px;  // index 8 is top left, 0 is bottom right
    logic [PixW-1:0]           target;
    logic                      typed;
    logic [PixW-1:0]           pix_typed;
  } stim_row_t;

  typedef struct packed {
    logic            kind;
    logic [PixW-1:0] pixel;
  } answer_t;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                command_i      = '0;
  logic [PatW-1:0][PixW-1:0] win_px         = '0;
  logic [PixW-1:0]           target_pixel_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic                      result_kind_o;
  logic [7:0]                out_pixel_o;

  logic [PixW-1:0] lut_value [Depth];
  bit              lut_known [Depth];
  answer_t         answer_q [$];

  int unsigned n_err     = 0;
  int unsigned n_checked = 0;
  int unsigned n_train   = 0;
  int unsigned n_query   = 0;
  int unsigned n_fill    = 0;
  int unsigned n_drop    = 0;
  int unsigned quiet     = 0;
  bit          calm      = 1'b0;

  always #5 clk_i = ~clk_i;

  learned_binary_window_table_filter u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .pixel_top_left_i    (win_px[8]),
    .pixel_top_i         (win_px[7]),
    .pixel_top_right_i   (win_px[6]),
    .pixel_left_i        (win_px[5]),
    .pixel_center_i      (win_px[4]),
    .pixel_right_i       (win_px[3]),
    .pixel_bottom_left_i (win_px[2]),
    .pixel_bottom_i      (win_px[1]),
    .pixel_bottom_right_i(win_px[0]),
    .target_pixel_i      (target_pixel_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_kind_o       (result_kind_o),
    .out_pixel_o         (out_pixel_o)
  );

  function automatic logic [PatW-1:0] window_code(logic [PatW-1:0][PixW-1:0] px);
    logic [PatW-1:0] code;
    for (int k = 0; k < PatW; k++) begin
      code[k] = |px[k];
    end
    return code;
  endfunction

  function automatic logic [PatW-1:0][PixW-1:0] pixels_for(logic [PatW-1:0] code,
                                                           logic [PixW-1:0] lvl);
    logic [PatW-1:0][PixW-1:0] px;
    for (int k = 0; k < PatW; k++) begin
      px[k] = code[k] ? lvl : '0;
    end
    return px;
  endfunction

  function automatic stim_row_t row(logic [1:0] cmd, logic [PatW-1:0] code,
                                   logic [PixW-1:0] lvl, logic [PixW-1:0] tgt,
                                   logic typed, logic [PixW-1:0] pix);
    stim_row_t r;
    r.cmd       = cmd;
    r.px        = pixels_for(code, lvl);
    r.target    = tgt;
    r.typed     = typed;
    r.pix_typed = pix;
    return r;
  endfunction

  // every unseen entry takes the first seen entry at the least distance,
  // entries resolved earlier in the walk count as seen
  function automatic void resolve_unseen();
    int unsigned     best;
    logic [PixW-1:0] pick;
    for (int i = 0; i < Depth; i++) begin
      if (!lut_known[i]) begin
        best = PatW + 1;
        pick = '0;
        for (int j = 0; j < Depth; j++) begin
          if (lut_known[j] && $countones(i ^ j) < best) begin
            best = $countones(i ^ j);
            pick = lut_value[j];
          end
        end
        lut_value[i] = pick;
        lut_known[i] = 1'b1;
      end
    end
  endfunction

  task automatic lut_apply(input stim_row_t r);
    logic [PatW-1:0] code;
    answer_t         a;
    bit              gives;
    code  = window_code(r.px);
    gives = 1'b0;
    a     = '0;
    case (r.cmd)
      lbwtf_pkg::CmdTrain: begin
        lut_value[code] = r.target;
        lut_known[code] = 1'b1;
        n_train++;
      end
      lbwtf_pkg::CmdFill: begin
        resolve_unseen();
        a.kind  = lbwtf_pkg::KindFill;
        a.pixel = '0;
        gives   = 1'b1;
        n_fill++;
      end
      lbwtf_pkg::CmdQuery: begin
        a.kind  = lbwtf_pkg::KindQuery;
        a.pixel = lut_value[code];
        gives   = 1'b1;
        n_query++;
      end
      default: begin
        n_drop++;
      end
    endcase
    if (gives) begin
      if (r.typed) a.pixel = r.pix_typed;
      answer_q.push_back(a);
    end
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input stim_row_t r);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= r.cmd;
    win_px         <= r.px;
    target_pixel_i <= r.target;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lut_apply(r);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with nothing pending: kind %0d pixel %0d",
                 $time, result_kind_o, out_pixel_o);
        n_err++;
      end else begin
        want = answer_q.pop_front();
        n_checked++;
        if (result_kind_o !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d",
                   $time, want.kind, result_kind_o);
          n_err++;
        end
        if (out_pixel_o !== want.pixel) begin
          $display("%0t: out_pixel expected %0d actual %0d",
                   $time, want.pixel, out_pixel_o);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    stim_row_t       dir_tab [DirN];
    stim_row_t       r;
    logic [PatW-1:0] last_code;
    int unsigned     pick;
    dir_tab = '{
      row(lbwtf_pkg::CmdQuery, 9'h000, 8'h01, 8'h00, 1'b1, 8'h80),  // unseen after reset
      row(lbwtf_pkg::CmdQuery, 9'h1FF, 8'hFF, 8'h00, 1'b1, 8'h80),
      row(CmdUnused,           9'h1FF, 8'hFF, 8'hFF, 1'b0, 8'h00),  // dropped, no write
      row(lbwtf_pkg::CmdQuery, 9'h1FF, 8'h80, 8'h00, 1'b1, 8'h80),
      row(lbwtf_pkg::CmdTrain, 9'h1FF, 8'h01, 8'hFF, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h1FF, 8'hFF, 8'h00, 1'b1, 8'hFF),
      row(lbwtf_pkg::CmdTrain, 9'h000, 8'hFF, 8'h00, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h000, 8'h01, 8'hFF, 1'b1, 8'h00),
      row(lbwtf_pkg::CmdTrain, 9'h155, 8'h55, 8'h80, 1'b0, 8'h00),  // seen entry holding 128
      row(lbwtf_pkg::CmdQuery, 9'h155, 8'hAA, 8'h00, 1'b1, 8'h80),
      row(lbwtf_pkg::CmdTrain, 9'h100, 8'h7F, 8'h07, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdTrain, 9'h001, 8'hFE, 8'hC8, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdTrain, 9'h0AA, 8'h02, 8'h3C, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdTrain, 9'h0F0, 8'h40, 8'h99, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h0AA, 8'h03, 8'h00, 1'b1, 8'h3C),
      row(lbwtf_pkg::CmdTrain, 9'h0AA, 8'h10, 8'hAA, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h0AA, 8'h20, 8'h00, 1'b1, 8'hAA),  // read right after write
      row(lbwtf_pkg::CmdFill,  9'h000, 8'h00, 8'h00, 1'b1, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h155, 8'h01, 8'h00, 1'b1, 8'h80),  // fill keeps trained 128
      row(lbwtf_pkg::CmdQuery, 9'h003, 8'hFF, 8'h00, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h1FE, 8'h01, 8'h00, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h0FF, 8'h0F, 8'h00, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h101, 8'hF0, 8'h00, 1'b0, 8'h00),  // tie, lower index wins
      row(CmdUnused,           9'h000, 8'h00, 8'h00, 1'b0, 8'h00),
      row(lbwtf_pkg::CmdQuery, 9'h000, 8'h00, 8'h00, 1'b1, 8'h00)
    };
    for (int i = 0; i < Depth; i++) begin
      lut_value[i] = lbwtf_pkg::UnseenVal;
      lut_known[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    last_code = '0;
    for (int n = 0; n < RandN; n++) begin
      calm        = (n >= CalmLo && n < CalmHi);
      pick        = $urandom_range(99);
      r.typed     = 1'b0;
      r.pix_typed = '0;
      r.target    = 8'($urandom_range(255));
      for (int k = 0; k < PatW; k++) begin
        r.px[k] = $urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'h00;
      end
      if (n == RandFillAt) begin
        r.cmd = lbwtf_pkg::CmdFill;
      end else if (pick < 8) begin
        r.cmd = CmdUnused;
      end else if (pick < 45) begin
        r.cmd = lbwtf_pkg::CmdTrain;
      end else begin
        r.cmd = lbwtf_pkg::CmdQuery;
        // revisit the last trained pattern with other gray levels
        if (pick >= 80) r.px = pixels_for(last_code, 8'($urandom_range(1, 255)));
      end
      if (r.cmd == lbwtf_pkg::CmdTrain) last_code = window_code(r.px);
      send_item(r);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("run: %0d trains, %0d queries, %0d fill walks, %0d unused commands",
             n_train, n_query, n_fill, n_drop);
    $display("run: %0d results compared, %0d mismatches", n_checked, n_err);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lbwtf_pkg.sv
hdl/lbwtf_ram.sv
hdl/learned_binary_window_table_filter.sv
tb/testbench.sv
